>>> rtl/text_console_cursor_scroll_core_defines.svh
// Assertion macros shared by the console cursor/scroll RTL.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define TCCS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define TCCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tccs_pkg.sv
// Package: types, constants and codes of the console cursor/scroll core.
`default_nettype none

package tccs_pkg;

    // geometry
    localparam int LINE_WIDTH   = 80;
    localparam int SCREEN_CELLS = 2000;

    localparam int ADDR_W    = 14;
    localparam int EXT_W     = ADDR_W + 1;
    localparam int LEN_W     = 11;
    localparam int BYTE_W    = 8;
    localparam int CX_W      = $clog2(LINE_WIDTH);
    localparam int LOOP_CAP  = 1024;
    localparam int ITER_W    = $clog2(LOOP_CAP + 1);
    localparam int NCMD      = 4;
    localparam int CMD_IDX_W = $clog2(NCMD);
    localparam int CMD_CNT_W = $clog2(NCMD + 1);

    // remainder unit
    localparam int DVD_W  = EXT_W;
    localparam int STEP_W = $clog2(DVD_W);

    // sized forms of the geometry
    localparam logic [ADDR_W-1:0] LW_A   = ADDR_W'(LINE_WIDTH);
    localparam logic [ADDR_W-1:0] SC_A   = ADDR_W'(SCREEN_CELLS);
    localparam logic [ADDR_W-1:0] BACK_A = ADDR_W'(SCREEN_CELLS - LINE_WIDTH);
    localparam logic [EXT_W-1:0]  LW_E   = EXT_W'(LINE_WIDTH);
    localparam logic [EXT_W-1:0]  SC_E   = EXT_W'(SCREEN_CELLS);
    localparam logic [LEN_W-1:0]  LW_L   = LEN_W'(LINE_WIDTH);
    localparam logic [LEN_W-1:0]  BACK_L = LEN_W'(SCREEN_CELLS - LINE_WIDTH);
    localparam logic [ITER_W-1:0] CAP_I  = ITER_W'(LOOP_CAP);

    // character codes
    localparam logic [BYTE_W-1:0] CHAR_NL = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_BS = 8'd8;
    localparam logic [BYTE_W-1:0] CHAR_SP = 8'd32;

    // stream widths
    localparam int IN_TDATA_W   = 8;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_FIELDS_W = 5 * ADDR_W - ADDR_W + LEN_W + 2 * BYTE_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int OUT_TUSER_W  = 2;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN  = 3'd0,
        CFG_WORDS   = 3'd1,
        CFG_CURRENT = 3'd2,
        CFG_WATTR   = 3'd3,
        CFG_CATTR   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_PUT  = 2'd0,
        ACT_UP   = 2'd1,
        ACT_DOWN = 2'd2,
        ACT_JUMP = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_COPY  = 2'd3
    } t_mem_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_NL_WAIT,
        ST_POST_START,
        ST_POST_WAIT,
        ST_OVF_COPY,
        ST_OVF_CLEAR,
        ST_NEW_START,
        ST_NEW_WAIT,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_UP,
        ST_DOWN,
        ST_JUMP,
        ST_LOOP,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_mem_op             op;
        logic [ADDR_W-1:0]   tgt;
        logic [ADDR_W-1:0]   src;
        logic [LEN_W-1:0]    len;
        logic [BYTE_W-1:0]   chr;
        logic [BYTE_W-1:0]   attr;
    } t_cmd;

    typedef struct packed {
        logic                start;
        logic [DVD_W-1:0]    dividend;
        logic [ADDR_W-1:0]   divisor;
    } t_mod_req;

    typedef struct packed {
        logic                done;
        logic [ADDR_W-1:0]   rem;
    } t_mod_rsp;

endpackage

`default_nettype wire

>>> rtl/tccs_mod.sv
// Iterative remainder unit: one restoring step per cycle.
`default_nettype none

module tccs_mod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tccs_pkg::t_mod_req  i_req,
    output tccs_pkg::t_mod_rsp  o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [tccs_pkg::STEP_W-1:0]    r_cnt;
    logic [tccs_pkg::DVD_W-1:0]     r_dvd;
    logic [tccs_pkg::ADDR_W-1:0]    r_dsr;
    logic [tccs_pkg::ADDR_W-1:0]    r_rem;

    logic [tccs_pkg::EXT_W-1:0]     w_trial;
    logic [tccs_pkg::EXT_W-1:0]     w_diff;
    logic [tccs_pkg::ADDR_W-1:0]    n_rem;

    // shift next dividend bit into the partial remainder, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[tccs_pkg::DVD_W-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        if (w_trial >= {1'b0, r_dsr}) begin
            n_rem = w_diff[tccs_pkg::ADDR_W-1:0];
        end else begin
            n_rem = w_trial[tccs_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= tccs_pkg::STEP_W'(tccs_pkg::DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[tccs_pkg::DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

>>> rtl/text_console_cursor_scroll_core.sv
// Top level: cursor, view and scroll-back sequencer of one text console.
`default_nettype none
`include "text_console_cursor_scroll_core_defines.svh"

// Text console cursor/scroll core. Each input request is one action
// (tuser: 0 put character, 1 scroll view up a line, 2 scroll view down a
// line, 3 jump to latest lines; tdata: character byte, 10 = newline,
// 8 = backspace). The core answers with one to four video memory commands
// (write cell, clear span, copy span, or a single "none" when nothing is
// written); tlast marks the final command of a request, and every command
// carries the cursor and display start as they stand after the whole request.
// update_crtc is the is_current register on the final command only.
// Timing: one request at a time; input ready is low from acceptance until the
// last command has been taken. All line arithmetic (column, line start, the
// oldest-line wrap of a full region) runs through one shared 15-step
// remainder unit. A put scrolls the view a line at a time until the cursor
// is visible or the view stops moving (at most 1024 lines), and output
// back-pressure stalls command delivery. Config writes (index 0 origin,
// 1 region words, 2 is_current, 3 write attr, 4 clear attr) are taken any
// cycle and should only be issued while the core is idle.
module text_console_cursor_scroll_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input request
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [tccs_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // [7:0] char_code
    input  logic [tccs_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,  // [1:0] action
    // command output
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [13:0] target_addr, [27:14] source_addr, [38:28] span_length,
    // [46:39] cell_char, [54:47] cell_attr, [68:55] cursor_pos,
    // [82:69] display_start, [83] update_crtc, [87:84] zero
    output logic [tccs_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic [tccs_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser,  // [1:0] mem_op
    output logic                                o_m_axis_tlast,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [tccs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tccs_pkg::ADDR_W-1:0]         i_cfg_data
);

    // ---------------- config registers ----------------
    logic [tccs_pkg::ADDR_W-1:0]    r_origin;
    logic [tccs_pkg::ADDR_W-1:0]    r_words;
    logic                           r_current;
    logic [tccs_pkg::BYTE_W-1:0]    r_wattr;
    logic [tccs_pkg::BYTE_W-1:0]    r_cattr;

    // ---------------- console state ----------------
    logic [tccs_pkg::ADDR_W-1:0]    r_cursor,  n_cursor;
    logic [tccs_pkg::ADDR_W-1:0]    r_view,    n_view;
    logic                           r_full,    n_full;

    // ---------------- sequencer ----------------
    tccs_pkg::t_state               r_state,   n_state;
    tccs_pkg::t_action              r_action;
    logic [tccs_pkg::BYTE_W-1:0]    r_char;
    logic [tccs_pkg::CX_W-1:0]      r_cx,      n_cx;      // column after the put
    logic [tccs_pkg::ADDR_W-1:0]    r_newest,  n_newest;  // offset of cursor line start
    logic [tccs_pkg::ADDR_W-1:0]    r_oldest,  n_oldest;  // offset of oldest kept line
    logic [tccs_pkg::ITER_W-1:0]    r_iter,    n_iter;
    logic [tccs_pkg::CMD_CNT_W-1:0] r_ncmd,    n_ncmd;
    logic [tccs_pkg::CMD_IDX_W-1:0] r_oidx,    n_oidx;
    tccs_pkg::t_cmd                 r_buf [tccs_pkg::NCMD];

    // ---------------- combinational ----------------
    logic                           w_in_acc;
    logic                           w_out_acc;
    logic                           w_out_last;
    logic                           w_emit;
    tccs_pkg::t_cmd                 w_cmd;
    tccs_pkg::t_cmd                 w_rd;
    tccs_pkg::t_mod_req             w_mod_req;
    tccs_pkg::t_mod_rsp             w_mod_rsp;

    logic [tccs_pkg::ADDR_W-1:0]    w_off;     // cursor offset in region, mod 2^14
    logic [tccs_pkg::ADDR_W-1:0]    w_top;     // view offset in region, mod 2^14
    logic [tccs_pkg::EXT_W-1:0]     w_top_end;
    logic [tccs_pkg::EXT_W-1:0]     w_lat;
    logic [tccs_pkg::ADDR_W-1:0]    w_up_view;
    logic [tccs_pkg::ADDR_W-1:0]    w_down_view;
    logic [tccs_pkg::ADDR_W-1:0]    w_jump_view;
    logic                           w_visible;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    assign w_off     = r_cursor - r_origin;
    assign w_top     = r_view - r_origin;
    assign w_top_end = {1'b0, w_top} + tccs_pkg::SC_E;

    // shared remainder unit (column, line start, oldest-line wrap)
    tccs_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_rsp   (w_mod_rsp)
    );

    // view after one line of scroll-up (toward newer text)
    always_comb begin
        w_up_view = r_view;
        if (!r_full && ({1'b0, r_newest} >= w_top_end)) begin
            w_up_view = r_view + tccs_pkg::LW_A;
        end else if (r_full && ((w_top_end - tccs_pkg::LW_E) != {1'b0, r_newest})) begin
            // wrap back to the origin once the view reaches the region end
            if (w_top_end == {1'b0, r_words}) begin
                w_up_view = r_origin;
            end else begin
                w_up_view = r_view + tccs_pkg::LW_A;
            end
        end
    end

    // view after one line of scroll-down (toward older text)
    always_comb begin
        w_down_view = r_view;
        if (!r_full && (w_top != '0)) begin
            w_down_view = r_view - tccs_pkg::LW_A;
        end else if (r_full && (w_top != r_oldest)) begin
            if (({1'b0, w_off} + tccs_pkg::SC_E) >= {1'b0, r_words}) begin
                // cursor sits in the last screen of the region
                if (r_view != r_origin) begin
                    w_down_view = r_view - tccs_pkg::LW_A;
                end
            end else if (r_view == r_origin) begin
                // wrap to the last screen of the region
                w_down_view = r_origin + r_words - tccs_pkg::SC_A;
            end else begin
                w_down_view = r_view - tccs_pkg::LW_A;
            end
        end
    end

    // jump: screen that ends with the cursor line, clamped at the origin
    always_comb begin
        w_lat = {1'b0, r_newest} + tccs_pkg::LW_E;
        if (w_lat < tccs_pkg::SC_E) begin
            w_jump_view = r_origin;
        end else begin
            w_jump_view = r_origin + w_lat[tccs_pkg::ADDR_W-1:0] - tccs_pkg::SC_A;
        end
    end

    // cursor inside [view, view + screen)
    assign w_visible = !(({1'b0, r_cursor} >= ({1'b0, r_view} + tccs_pkg::SC_E))
                         || (r_cursor < r_view));

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            tccs_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = tccs_pkg::ST_DISPATCH;
                end
            end
            tccs_pkg::ST_DISPATCH: begin
                if (r_action == tccs_pkg::ACT_PUT) begin
                    if (r_char == tccs_pkg::CHAR_NL) begin
                        n_state = tccs_pkg::ST_NL_WAIT;
                    end else begin
                        n_state = tccs_pkg::ST_POST_START;
                    end
                end else begin
                    n_state = tccs_pkg::ST_NEW_WAIT;
                end
            end
            tccs_pkg::ST_NL_WAIT: begin
                if (w_mod_rsp.done) begin
                    n_state = tccs_pkg::ST_POST_START;
                end
            end
            tccs_pkg::ST_POST_START: n_state = tccs_pkg::ST_POST_WAIT;
            tccs_pkg::ST_POST_WAIT: begin
                if (w_mod_rsp.done) begin
                    if (w_off >= r_words) begin
                        n_state = tccs_pkg::ST_OVF_COPY;
                    end else begin
                        n_state = tccs_pkg::ST_LOOP;
                    end
                end
            end
            tccs_pkg::ST_OVF_COPY:  n_state = tccs_pkg::ST_OVF_CLEAR;
            tccs_pkg::ST_OVF_CLEAR: n_state = tccs_pkg::ST_NEW_START;
            tccs_pkg::ST_NEW_START: n_state = tccs_pkg::ST_NEW_WAIT;
            tccs_pkg::ST_NEW_WAIT: begin
                if (w_mod_rsp.done) begin
                    case (r_action)
                        tccs_pkg::ACT_PUT:  n_state = tccs_pkg::ST_LOOP;
                        tccs_pkg::ACT_UP:   n_state = tccs_pkg::ST_UP;
                        tccs_pkg::ACT_DOWN: begin
                            if (r_full && (r_words != '0)) begin
                                n_state = tccs_pkg::ST_MOD_START;
                            end else begin
                                n_state = tccs_pkg::ST_DOWN;
                            end
                        end
                        tccs_pkg::ACT_JUMP: n_state = tccs_pkg::ST_JUMP;
                        default:            n_state = tccs_pkg::ST_FIN;
                    endcase
                end
            end
            tccs_pkg::ST_MOD_START: n_state = tccs_pkg::ST_MOD_WAIT;
            tccs_pkg::ST_MOD_WAIT: begin
                if (w_mod_rsp.done) begin
                    n_state = tccs_pkg::ST_DOWN;
                end
            end
            tccs_pkg::ST_UP:   n_state = tccs_pkg::ST_FIN;
            tccs_pkg::ST_DOWN: n_state = tccs_pkg::ST_FIN;
            tccs_pkg::ST_JUMP: n_state = tccs_pkg::ST_FIN;
            tccs_pkg::ST_LOOP: begin
                // stop when visible, at the cap, or when a scroll does nothing
                if (w_visible || (r_iter == tccs_pkg::CAP_I) || (w_up_view == r_view)) begin
                    n_state = tccs_pkg::ST_FIN;
                end
            end
            tccs_pkg::ST_FIN: n_state = tccs_pkg::ST_OUT;
            tccs_pkg::ST_OUT: begin
                if (w_out_acc && w_out_last) begin
                    n_state = tccs_pkg::ST_IDLE;
                end
            end
            default: n_state = tccs_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath / outputs of the sequencer ----------------
    always_comb begin
        n_cursor  = r_cursor;
        n_view    = r_view;
        n_full    = r_full;
        n_cx      = r_cx;
        n_newest  = r_newest;
        n_oldest  = r_oldest;
        n_iter    = r_iter;
        n_oidx    = r_oidx;
        w_emit    = 1'b0;
        w_cmd     = '0;
        w_mod_req.start    = 1'b0;
        w_mod_req.dividend = {1'b0, w_off};
        w_mod_req.divisor  = tccs_pkg::LW_A;

        case (r_state)
            tccs_pkg::ST_IDLE: begin
                n_iter = '0;
            end
            tccs_pkg::ST_DISPATCH: begin
                if (r_action == tccs_pkg::ACT_PUT) begin
                    if (r_char == tccs_pkg::CHAR_NL) begin
                        w_mod_req.start = 1'b1;
                    end else if (r_char == tccs_pkg::CHAR_BS) begin
                        if (r_cursor > r_origin) begin
                            n_cursor   = r_cursor - 1'b1;
                            w_emit     = 1'b1;
                            w_cmd.op   = tccs_pkg::OP_WRITE;
                            w_cmd.tgt  = r_cursor - 1'b1;
                            w_cmd.chr  = tccs_pkg::CHAR_SP;
                            w_cmd.attr = r_wattr;
                        end
                    end else begin
                        n_cursor   = r_cursor + 1'b1;
                        w_emit     = 1'b1;
                        w_cmd.op   = tccs_pkg::OP_WRITE;
                        w_cmd.tgt  = r_cursor;
                        w_cmd.chr  = r_char;
                        w_cmd.attr = r_wattr;
                    end
                end else begin
                    w_mod_req.start = 1'b1;
                end
            end
            tccs_pkg::ST_NL_WAIT: begin
                if (w_mod_rsp.done) begin
                    // clear to end of line, cursor to next line start
                    n_cursor   = r_cursor - w_mod_rsp.rem + tccs_pkg::LW_A;
                    w_emit     = 1'b1;
                    w_cmd.op   = tccs_pkg::OP_CLEAR;
                    w_cmd.tgt  = r_cursor;
                    w_cmd.len  = tccs_pkg::LW_L - tccs_pkg::LEN_W'(w_mod_rsp.rem);
                    w_cmd.chr  = tccs_pkg::CHAR_SP;
                    w_cmd.attr = r_cattr;
                end
            end
            tccs_pkg::ST_POST_START: begin
                w_mod_req.start = 1'b1;
            end
            tccs_pkg::ST_POST_WAIT: begin
                if (w_mod_rsp.done) begin
                    n_cx     = w_mod_rsp.rem[tccs_pkg::CX_W-1:0];
                    n_newest = w_off - w_mod_rsp.rem;
                end
            end
            tccs_pkg::ST_OVF_COPY: begin
                // keep the last screen minus one line at the origin
                w_emit     = 1'b1;
                w_cmd.op   = tccs_pkg::OP_COPY;
                w_cmd.tgt  = r_origin;
                w_cmd.src  = r_cursor - tccs_pkg::ADDR_W'(r_cx) + tccs_pkg::LW_A
                             - tccs_pkg::SC_A;
                w_cmd.len  = tccs_pkg::BACK_L;
                n_view     = r_origin;
                n_cursor   = r_origin + tccs_pkg::BACK_A + tccs_pkg::ADDR_W'(r_cx);
                n_full     = 1'b1;
            end
            tccs_pkg::ST_OVF_CLEAR: begin
                w_emit     = 1'b1;
                w_cmd.op   = tccs_pkg::OP_CLEAR;
                w_cmd.tgt  = r_cursor;
                w_cmd.len  = tccs_pkg::LW_L - tccs_pkg::LEN_W'(r_cx);
                w_cmd.chr  = tccs_pkg::CHAR_SP;
                w_cmd.attr = r_cattr;
            end
            tccs_pkg::ST_NEW_START: begin
                w_mod_req.start = 1'b1;
            end
            tccs_pkg::ST_NEW_WAIT: begin
                if (w_mod_rsp.done) begin
                    n_newest = w_off - w_mod_rsp.rem;
                    n_oldest = '0;
                end
            end
            tccs_pkg::ST_MOD_START: begin
                w_mod_req.start    = 1'b1;
                w_mod_req.dividend = {1'b0, r_newest} + tccs_pkg::LW_E;
                w_mod_req.divisor  = r_words;
            end
            tccs_pkg::ST_MOD_WAIT: begin
                if (w_mod_rsp.done) begin
                    n_oldest = w_mod_rsp.rem;
                end
            end
            tccs_pkg::ST_UP: begin
                n_view = w_up_view;
            end
            tccs_pkg::ST_DOWN: begin
                n_view = w_down_view;
            end
            tccs_pkg::ST_JUMP: begin
                n_view = w_jump_view;
            end
            tccs_pkg::ST_LOOP: begin
                if (!w_visible && (r_iter != tccs_pkg::CAP_I)) begin
                    n_view = w_up_view;
                    n_iter = r_iter + 1'b1;
                    // the loop's clear is the same every pass: issue it once
                    if (r_iter == '0) begin
                        w_emit     = 1'b1;
                        w_cmd.op   = tccs_pkg::OP_CLEAR;
                        w_cmd.tgt  = r_cursor;
                        w_cmd.len  = tccs_pkg::LW_L - tccs_pkg::LEN_W'(r_cx);
                        w_cmd.chr  = tccs_pkg::CHAR_SP;
                        w_cmd.attr = r_cattr;
                    end
                end
            end
            tccs_pkg::ST_FIN: begin
                // a request that writes nothing still answers once
                if (r_ncmd == '0) begin
                    w_emit = 1'b1;
                end
                n_oidx = '0;
            end
            tccs_pkg::ST_OUT: begin
                if (w_out_acc) begin
                    n_oidx = r_oidx + 1'b1;
                end
            end
            default: begin
                n_iter = '0;
            end
        endcase
    end

    always_comb begin
        n_ncmd = r_ncmd;
        if (r_state == tccs_pkg::ST_IDLE) begin
            n_ncmd = '0;
        end else if (w_emit && (r_ncmd < tccs_pkg::CMD_CNT_W'(tccs_pkg::NCMD))) begin
            n_ncmd = r_ncmd + 1'b1;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin  <= '0;
            r_words   <= 14'd5440;
            r_current <= 1'b1;
            r_wattr   <= 8'd7;
            r_cattr   <= 8'd7;
        end else if (i_cfg_we) begin
            case (tccs_pkg::t_cfg_idx'(i_cfg_idx))
                tccs_pkg::CFG_ORIGIN:  r_origin  <= i_cfg_data;
                tccs_pkg::CFG_WORDS:   r_words   <= i_cfg_data;
                tccs_pkg::CFG_CURRENT: r_current <= i_cfg_data[0];
                tccs_pkg::CFG_WATTR:   r_wattr   <= i_cfg_data[tccs_pkg::BYTE_W-1:0];
                tccs_pkg::CFG_CATTR:   r_cattr   <= i_cfg_data[tccs_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tccs_pkg::ST_IDLE;
            r_cursor <= '0;
            r_view   <= '0;
            r_full   <= 1'b0;
            r_iter   <= '0;
            r_ncmd   <= '0;
            r_oidx   <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_view   <= n_view;
            r_full   <= n_full;
            r_iter   <= n_iter;
            r_ncmd   <= n_ncmd;
            r_oidx   <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_action <= tccs_pkg::t_action'(i_s_axis_tuser);
            r_char   <= i_s_axis_tdata;
        end
        r_cx     <= n_cx;
        r_newest <= n_newest;
        r_oldest <= n_oldest;
        if (w_emit && (r_ncmd < tccs_pkg::CMD_CNT_W'(tccs_pkg::NCMD))) begin
            r_buf[r_ncmd[tccs_pkg::CMD_IDX_W-1:0]] <= w_cmd;
        end
    end

    // ---------------- ports ----------------
    assign o_s_axis_tready = (r_state == tccs_pkg::ST_IDLE);
    assign o_m_axis_tvalid = (r_state == tccs_pkg::ST_OUT);

    assign w_rd       = r_buf[r_oidx];
    assign w_out_last = ((tccs_pkg::CMD_CNT_W'(r_oidx) + 1'b1) == r_ncmd);

    assign o_m_axis_tuser = w_rd.op;
    assign o_m_axis_tlast = w_out_last;
    assign o_m_axis_tdata = {{tccs_pkg::OUT_PAD_W{1'b0}},
                             w_out_last & r_current,
                             r_view,
                             r_cursor,
                             w_rd.attr,
                             w_rd.chr,
                             w_rd.len,
                             w_rd.src,
                             w_rd.tgt};

    // ---------------- assertions ----------------
    `TCCS_ASSERT_ALWAYS(a_one_side, i_clk, i_rst_n, !(o_s_axis_tready && o_m_axis_tvalid), "input and output both open")
    `TCCS_ASSERT_NOW(a_out_idx, i_clk, i_rst_n, o_m_axis_tvalid, ({1'b0, r_oidx} < r_ncmd), "command index past buffer fill")
    `TCCS_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, (w_out_acc && o_m_axis_tlast), o_s_axis_tready, "not ready after last command")
    `TCCS_ASSERT_NEXT(a_full_sticky, i_clk, i_rst_n, r_full, r_full, "region full flag dropped")
    `TCCS_ASSERT_NOW(a_mod_waited, i_clk, i_rst_n, w_mod_rsp.done, ((r_state == tccs_pkg::ST_NL_WAIT) || (r_state == tccs_pkg::ST_POST_WAIT) || (r_state == tccs_pkg::ST_NEW_WAIT) || (r_state == tccs_pkg::ST_MOD_WAIT)), "remainder result with no waiter")

endmodule

`default_nettype wire

>>> dv/tccs_cmd_checker.sv
`timescale 1ns / 100ps
// Checker for the console core: tracks cursor/view state, predicts memory commands, compares.
module tccs_cmd_checker
    import tccs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [7:0] char_code
    input  logic [IN_TUSER_W-1:0]  i_s_tuser,   // [1:0] action
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // [13:0] target, [27:14] source, [38:28] length, [46:39] char, [54:47] attr,
    // [68:55] cursor, [82:69] display start, [83] update_crtc, [87:84] zero
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic [OUT_TUSER_W-1:0] i_m_tuser,   // [1:0] mem_op
    input  logic                   i_m_tlast,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ADDR_W-1:0]      i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct {
        t_cmd              cmd;
        logic [ADDR_W-1:0] cursor;
        logic [ADDR_W-1:0] view;
        logic              crtc;
        logic              last;
    } t_console_result;

    // register copies
    logic [ADDR_W-1:0] origin_r;
    logic [ADDR_W-1:0] words_r;
    logic              current_r;
    logic [BYTE_W-1:0] wattr_r;
    logic [BYTE_W-1:0] cattr_r;
    // console state
    logic [ADDR_W-1:0] cursor_r;
    logic [ADDR_W-1:0] view_r;
    logic              full_r;

    t_cmd            step_cmds[$];
    t_console_result pending_cmds[$];
    int              errors = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int as_int(logic [ADDR_W-1:0] v);
        int r;
        r = 0;
        r[ADDR_W-1:0] = v;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_addr(int v);
        return v[ADDR_W-1:0];
    endfunction

    // offset from the console origin, wrapped at 14 bits
    function automatic int rel_off(logic [ADDR_W-1:0] addr);
        return as_int(addr - origin_r);
    endfunction

    function automatic void push_cmd(t_mem_op op, logic [ADDR_W-1:0] tgt,
                                     logic [ADDR_W-1:0] src, int len,
                                     logic [BYTE_W-1:0] chr, logic [BYTE_W-1:0] attr);
        t_cmd c;
        if (step_cmds.size() >= NCMD) return;
        c.op   = op;
        c.tgt  = tgt;
        c.src  = src;
        c.len  = len[LEN_W-1:0];
        c.chr  = chr;
        c.attr = attr;
        step_cmds.push_back(c);
    endfunction

    function automatic void scroll_view(bit up);
        int size, org, off, newest, oldest, top;
        size   = as_int(words_r);
        org    = as_int(origin_r);
        off    = rel_off(cursor_r);
        newest = off / LINE_WIDTH * LINE_WIDTH;
        oldest = 0;
        top    = rel_off(view_r);
        if (full_r && size != 0) oldest = (newest + LINE_WIDTH) % size;
        if (!up) begin
            if (!full_r && top > 0) begin
                view_r = view_r - LW_A;
            end else if (full_r && top != oldest) begin
                if (off >= size - SCREEN_CELLS) begin
                    if (view_r != origin_r) view_r = view_r - LW_A;
                end else if (view_r == origin_r) begin
                    // wrap back to the tail of the region
                    view_r = wrap_addr(org + size - SCREEN_CELLS);
                end else begin
                    view_r = view_r - LW_A;
                end
            end
        end else begin
            if (!full_r && newest >= top + SCREEN_CELLS) begin
                view_r = view_r + LW_A;
            end else if (full_r && top + SCREEN_CELLS - LINE_WIDTH != newest) begin
                if (top + SCREEN_CELLS == size) view_r = origin_r;
                else view_r = view_r + LW_A;
            end
        end
    endfunction

    function automatic void put_character(logic [BYTE_W-1:0] ch);
        int org, off, cx, cy, i, cur_i, view_i;
        logic [ADDR_W-1:0] prior;
        org = as_int(origin_r);
        off = rel_off(cursor_r);
        cx  = off % LINE_WIDTH;
        cy  = off / LINE_WIDTH;
        if (ch == CHAR_NL) begin
            push_cmd(OP_CLEAR, cursor_r, '0, LINE_WIDTH - cx, CHAR_SP, cattr_r);
            cursor_r = wrap_addr(org + LINE_WIDTH * (cy + 1));
        end else if (ch == CHAR_BS) begin
            if (cursor_r > origin_r) begin
                cursor_r = cursor_r - 1'b1;
                push_cmd(OP_WRITE, cursor_r, '0, 0, CHAR_SP, wattr_r);
            end
        end else begin
            push_cmd(OP_WRITE, cursor_r, '0, 0, ch, wattr_r);
            cursor_r = cursor_r + 1'b1;
        end
        off = rel_off(cursor_r);
        cx  = off % LINE_WIDTH;
        cy  = off / LINE_WIDTH;
        // region overflow: keep the last screen minus one line at the origin
        if (off >= as_int(words_r)) begin
            push_cmd(OP_COPY, origin_r, wrap_addr(org + (cy + 1) * LINE_WIDTH - SCREEN_CELLS),
                     SCREEN_CELLS - LINE_WIDTH, '0, '0);
            view_r   = origin_r;
            cursor_r = wrap_addr(org + SCREEN_CELLS - LINE_WIDTH + cx);
            push_cmd(OP_CLEAR, cursor_r, '0, LINE_WIDTH - cx, CHAR_SP, cattr_r);
            full_r   = 1'b1;
        end
        // follow the cursor; the clear goes out once however long the loop runs
        for (i = 0; i < LOOP_CAP; i++) begin
            prior  = view_r;
            cur_i  = as_int(cursor_r);
            view_i = as_int(view_r);
            if (!(cur_i >= view_i + SCREEN_CELLS || cur_i < view_i)) break;
            scroll_view(1'b1);
            if (i == 0) push_cmd(OP_CLEAR, cursor_r, '0, LINE_WIDTH - cx, CHAR_SP, cattr_r);
            if (view_r == prior) break;
        end
    endfunction

    function automatic void predict_console_step(t_action act, logic [BYTE_W-1:0] ch);
        int latest, k;
        t_console_result res;
        step_cmds.delete();
        case (act)
            ACT_PUT:  put_character(ch);
            ACT_UP:   scroll_view(1'b1);
            ACT_DOWN: scroll_view(1'b0);
            default: begin
                latest = rel_off(cursor_r) / LINE_WIDTH * LINE_WIDTH + LINE_WIDTH - SCREEN_CELLS;
                if (latest < 0) latest = 0;
                view_r = wrap_addr(as_int(origin_r) + latest);
            end
        endcase
        if (step_cmds.size() == 0) push_cmd(OP_NONE, '0, '0, 0, '0, '0);
        for (k = 0; k < step_cmds.size(); k++) begin
            res.cmd    = step_cmds[k];
            res.cursor = cursor_r;
            res.view   = view_r;
            res.last   = (k == step_cmds.size() - 1);
            res.crtc   = res.last ? current_r : 1'b0;
            pending_cmds.push_back(res);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_console_result want;
        if (!i_rst_n) begin
            origin_r  = '0;
            words_r   = 14'd5440;
            current_r = 1'b1;
            wattr_r   = 8'd7;
            cattr_r   = 8'd7;
            cursor_r  = '0;
            view_r    = '0;
            full_r    = 1'b0;
            pending_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ORIGIN:  origin_r  = i_cfg_data;
                    CFG_WORDS:   words_r   = i_cfg_data;
                    CFG_CURRENT: current_r = i_cfg_data[0];
                    CFG_WATTR:   wattr_r   = i_cfg_data[BYTE_W-1:0];
                    CFG_CATTR:   cattr_r   = i_cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                predict_console_step(t_action'(i_s_tuser), i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (pending_cmds.size() == 0) begin
                    $display("%0t: command mismatch: expected none, got op %0d", $time, i_m_tuser);
                    errors++;
                end else begin
                    want = pending_cmds.pop_front();
                    check_field("mem_op",        want.cmd.op,   i_m_tuser);
                    check_field("target_addr",   want.cmd.tgt,  i_m_tdata[13:0]);
                    check_field("source_addr",   want.cmd.src,  i_m_tdata[27:14]);
                    check_field("span_length",   want.cmd.len,  i_m_tdata[38:28]);
                    check_field("cell_char",     want.cmd.chr,  i_m_tdata[46:39]);
                    check_field("cell_attr",     want.cmd.attr, i_m_tdata[54:47]);
                    check_field("cursor_pos",    want.cursor,   i_m_tdata[68:55]);
                    check_field("display_start", want.view,     i_m_tdata[82:69]);
                    check_field("update_crtc",   want.crtc,     i_m_tdata[83]);
                    check_field("pad",           0,             i_m_tdata[87:84]);
                    check_field("last",          want.last,     i_m_tlast);
                end
            end
        end
        o_fail_count <= errors;
        o_pending    <= pending_cmds.size();
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, request and config stimulus, and the verdict for the console core.
module tb_top;
    import tccs_pkg::*;

    localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 64;    // quiet time after the last command

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request side
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data  = '0;
    logic [IN_TUSER_W-1:0]  s_user  = '0;
    // command side
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    logic [OUT_TUSER_W-1:0] m_user;
    logic                   m_last;
    // register writes
    logic                   cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx  = '0;
    logic [ADDR_W-1:0]      cfg_data = '0;

    // traffic shaping shared with the receiver process
    logic idle_on  = 1'b0;
    logic hold_arm = 1'b0;

    int fail_count;
    int pending;

    text_console_cursor_scroll_core DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    tccs_cmd_checker u_cmd_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_user),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_m_tuser    (m_user),
        .i_m_tlast    (m_last),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // synchronous reset, held low from time zero, never asserted again
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // hard stop well past the slowest legal run
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Command receiver: random stall bursts while idling is on, plus one long
    // hold-off once armed so the core backs up and drops its input ready.
    initial begin : rx_side
        int  n;
        bit  held;
        held = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_arm && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 15);
                repeat (n) @(posedge clk);
            end else begin
                m_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // One request: optional gap burst, then hold valid until the core takes it.
    // Valid stays high across back-to-back requests.
    task automatic send_request(t_action act, logic [7:0] ch);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= act;
        s_data  <= ch;
        do @(posedge clk); while (!s_ready);
    endtask

    // Stop offering and wait until every predicted command has come back.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [ADDR_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Full register set; only called with the core idle.
    task automatic program_console(logic [ADDR_W-1:0] org, logic [ADDR_W-1:0] words,
                                   logic cur, logic [7:0] wa, logic [7:0] ca);
        write_reg(CFG_ORIGIN,  org);
        write_reg(CFG_WORDS,   words);
        write_reg(CFG_CURRENT, {{(ADDR_W-1){1'b0}}, cur});
        write_reg(CFG_WATTR,   {6'd0, wa});
        write_reg(CFG_CATTR,   {6'd0, ca});
        cfg_we <= 1'b0;
    endtask

    // Terminal-like traffic: mostly text and newlines so the region fills and
    // the view has to follow, with scroll-back excursions and jumps mixed in.
    task automatic send_random(int count, int nl_pct);
        int sent, r, burst;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < nl_pct) begin
                send_request(ACT_PUT, CHAR_NL);
            end else if (r < 65) begin
                send_request(ACT_PUT, 8'($urandom_range(32, 126)));
            end else if (r < 70) begin
                send_request(ACT_PUT, CHAR_BS);
            end else if (r < 76) begin
                send_request(ACT_PUT, 8'($urandom_range(0, 255)));
            end else if (r < 86) begin
                // walk a few lines back into the history
                burst = $urandom_range(1, 6);
                repeat (burst) send_request(ACT_DOWN, 8'($urandom));
                sent += burst - 1;
            end else if (r < 94) begin
                send_request(ACT_UP, 8'($urandom));
            end else begin
                send_request(ACT_JUMP, 8'($urandom));
            end
            sent++;
        end
    endtask

    task automatic run_phase(logic [ADDR_W-1:0] org, logic [ADDR_W-1:0] words, logic cur,
                             logic [7:0] wa, logic [7:0] ca, int count, int nl_pct,
                             logic idle);
        settle();
        idle_on <= idle;
        program_console(org, words, cur, wa, ca);
        send_random(count, nl_pct);
    endtask

    initial begin : stimulus
        @(posedge clk);
        while (!rst_n) @(posedge clk);

        // Directed, reset-like settings: plain writes with extreme bytes,
        // backspaces down to and past the origin (last one writes nothing),
        // newline, and each view action on an empty history.
        program_console(14'd0, 14'd5440, 1'b1, 8'd7, 8'd7);
        send_request(ACT_PUT, 8'd65);
        send_request(ACT_PUT, 8'h00);
        send_request(ACT_PUT, 8'hFF);
        repeat (4) send_request(ACT_PUT, CHAR_BS);
        send_request(ACT_PUT, CHAR_NL);
        send_request(ACT_PUT, 8'd120);
        send_request(ACT_UP,   8'd0);
        send_request(ACT_DOWN, 8'd0);
        send_request(ACT_JUMP, 8'd0);

        // Directed, two-line region smaller than a screen: once it fills, every
        // put overflows (copy plus clear), then scroll-back on a full region.
        settle();
        program_console(14'd0, 14'd160, 1'b1, 8'h5A, 8'hA5);
        send_request(ACT_PUT, CHAR_NL);
        send_request(ACT_PUT, CHAR_NL);
        send_request(ACT_PUT, 8'd113);
        send_request(ACT_DOWN, 8'd0);
        send_request(ACT_DOWN, 8'd0);
        send_request(ACT_UP,   8'd0);
        send_request(ACT_JUMP, 8'd0);

        // Short region just over a screen: newline-heavy so it wraps often.
        run_phase(14'd0, 14'd2160, 1'b1, 8'($urandom), 8'($urandom), 65, 45, 1'b1);

        // Top-of-memory origin, largest region, console not shown; the
        // receiver holds off part way through while requests keep coming.
        run_phase(14'd16383, 14'd16383, 1'b0, 8'hFF, 8'h00, 20, 30, 1'b1);
        hold_arm <= 1'b1;
        send_random(20, 30);

        // Empty region: every put overflows. No idling here.
        run_phase(14'($urandom_range(0, 16383)), 14'd0, 1'b1, 8'h00, 8'hFF, 25, 20, 1'b0);

        // Offset origin, mid-size region.
        run_phase(14'd1000, 14'd4000, 1'b1, 8'($urandom), 8'($urandom), 75, 35, 1'b1);

        // Closing stretch on reset settings, both sides streaming.
        run_phase(14'd0, 14'd5440, 1'b1, 8'd7, 8'd7, 45, 40, 1'b0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
